@@ design/mahd_pkg.sv @@
package mahd_pkg;

    localparam int MAX_WINDOW = 1024;

    localparam int PTR_W    = $clog2(MAX_WINDOW);
    localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 11;
    localparam int SUM_W    = 42;
    localparam int IDX_W    = 32;
    localparam int POS_W    = 33;
    localparam int PROD_W   = SAMPLE_W + LEN_W + 1;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_THRESHOLD   = 2'd2;

    localparam logic EVT_START = 1'b0;
    localparam logic EVT_END   = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
    } t_event;

endpackage

@@ design/mahd_ram.sv @@
module mahd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/moving_average_hysteresis_detector.sv @@
// Moving-average detector with hysteresis for one stream of Q16.16 log-likelihood samples.
// Slave stream: one sample per item on i_s_tdata; accepted when i_s_tvalid and o_s_tready.
// Master stream: one event item for some samples; o_m_tuser is the kind (0 start,
// 1 end) and o_m_tdata the signed position (sample index minus window length).
// Config channel: i_cfg_addr selects window length, start threshold or end threshold;
// o_cfg_ready is always high. Write it only while no items are in flight.
// Throughput: one item per cycle while o_s_tready is high. The sample ring sits in a
// single-port-write, one-read RAM; the sample is written and the outgoing sample read at
// accept, the running sum is updated from stage 1 and the threshold compare runs on stage 2.
// A firing compare loads the output register, which drives o_m_tvalid, or the skid entry.
// The threshold products are formed at accept, one 32 x 11 multiply per threshold.
// Stall: an output register plus one skid entry; the pipeline freezes and o_s_tready
// drops only once the skid entry holds a result.
// Reset (synchronous, i_rst_n low): sum, sample count, ring pointer and state go to
// zero and idle, window length to 1, thresholds to 0. Ring contents are not cleared;
// an old entry is only subtracted after it has been written, so no clearing pass is needed.
module moving_average_hysteresis_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [31:0]                        i_s_tdata,  // log_prob
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mahd_pkg::OUT_DATA_W-1:0]    o_m_tdata,  // event_position, zero fill
    output logic                               o_m_tuser,  // event_kind
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mahd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [mahd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PTR_W    = mahd_pkg::PTR_W;
    localparam int LEN_W    = mahd_pkg::LEN_W;
    localparam int SAMPLE_W = mahd_pkg::SAMPLE_W;
    localparam int SUM_W    = mahd_pkg::SUM_W;
    localparam int IDX_W    = mahd_pkg::IDX_W;
    localparam int POS_W    = mahd_pkg::POS_W;
    localparam int PROD_W   = mahd_pkg::PROD_W;

    // configuration
    logic [mahd_pkg::WLEN_W-1:0] r_window_length;
    logic [SAMPLE_W-1:0]         r_start_threshold;
    logic [SAMPLE_W-1:0]         r_end_threshold;

    // stream state
    logic [IDX_W-1:0]  r_sample_index;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [SUM_W-1:0]  r_window_sum;
    logic              r_in_sound;

    // stage 1
    logic                     r1_valid;
    logic [SAMPLE_W-1:0]      r1_sample;
    logic                     r1_full;
    logic signed [PROD_W-1:0] r1_prod_start;
    logic signed [PROD_W-1:0] r1_prod_end;
    logic [POS_W-1:0]         r1_pos;

    // stage 2
    logic                     r2_valid;
    logic signed [PROD_W-1:0] r2_prod_start;
    logic signed [PROD_W-1:0] r2_prod_end;
    logic [POS_W-1:0]         r2_pos;

    // output register and skid entry
    logic                 r_out_valid;
    mahd_pkg::t_event     r_out;
    logic                 r_skid_valid;
    mahd_pkg::t_event     r_skid;

    logic                     w_en;
    logic                     w_in_fire;
    logic [LEN_W-1:0]         w_len;
    logic [LEN_W:0]           w_ptr_ext;
    logic [LEN_W:0]           w_len_ext;
    logic [PTR_W-1:0]         w_raddr;
    logic [LEN_W-1:0]         w_count;
    logic [SAMPLE_W-1:0]      w_old;
    logic [SUM_W-1:0]         n_window_sum;
    logic signed [PROD_W-1:0] n_prod_start;
    logic signed [PROD_W-1:0] n_prod_end;
    logic signed [PROD_W-1:0] w_sum_ext;
    logic                     w_res_valid;
    mahd_pkg::t_event         w_res;
    logic                     w_res_fire;

    assign w_en      = !r_skid_valid;
    assign o_s_tready = w_en;
    assign w_in_fire = i_s_tvalid && w_en;
    assign o_cfg_ready = 1'b1;

    // effective window length: zero acts as one, saturates at the ring depth
    always_comb begin
        if (r_window_length == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_window_length) > 32'(mahd_pkg::MAX_WINDOW)) begin
            w_len = LEN_W'(mahd_pkg::MAX_WINDOW);
        end else begin
            w_len = LEN_W'(r_window_length);
        end
    end

    // address of the sample leaving the window
    always_comb begin
        w_ptr_ext = (LEN_W + 1)'(r_wr_ptr);
        w_len_ext = (LEN_W + 1)'(w_len);
        if (w_ptr_ext >= w_len_ext) begin
            w_raddr = PTR_W'(w_ptr_ext - w_len_ext);
        end else begin
            w_raddr = PTR_W'(w_ptr_ext + (LEN_W + 1)'(mahd_pkg::MAX_WINDOW) - w_len_ext);
        end
    end

    always_comb begin
        if (r_sample_index < IDX_W'(w_len)) begin
            w_count = LEN_W'(r_sample_index + 1'b1);
        end else begin
            w_count = w_len;
        end
        n_prod_start = PROD_W'($signed(r_start_threshold)) * PROD_W'($signed({1'b0, w_count}));
        n_prod_end   = PROD_W'($signed(r_end_threshold)) * PROD_W'($signed({1'b0, w_count}));
    end

    mahd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (mahd_pkg::MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_in_fire),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_s_tdata),
        .i_re    (w_in_fire),
        .i_raddr (w_raddr),
        .o_rdata (w_old)
    );

    // running sum update
    always_comb begin
        n_window_sum = r_window_sum + SUM_W'($signed(r1_sample));
        if (r1_full) begin
            n_window_sum = n_window_sum - SUM_W'($signed(w_old));
        end
    end

    // hysteresis decision
    always_comb begin
        w_sum_ext = PROD_W'($signed(r_window_sum));
        w_res.position = r2_pos;
        if (!r_in_sound) begin
            w_res_valid = w_sum_ext >= r2_prod_start;
            w_res.kind  = mahd_pkg::EVT_START;
        end else begin
            w_res_valid = w_sum_ext < r2_prod_end;
            w_res.kind  = mahd_pkg::EVT_END;
        end
    end

    assign w_res_fire = w_en && r2_valid && w_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length   <= mahd_pkg::WLEN_W'(1);
            r_start_threshold <= '0;
            r_end_threshold   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                mahd_pkg::CFG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_data[mahd_pkg::WLEN_W-1:0];
                end
                mahd_pkg::CFG_START_THRESHOLD: begin
                    r_start_threshold <= i_cfg_data;
                end
                mahd_pkg::CFG_END_THRESHOLD: begin
                    r_end_threshold <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_wr_ptr       <= '0;
            r_window_sum   <= '0;
            r_in_sound     <= 1'b0;
            r1_valid       <= 1'b0;
            r2_valid       <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_in_fire;
            r2_valid <= r1_valid;
            if (w_in_fire) begin
                if (r_sample_index != '1) begin
                    r_sample_index <= r_sample_index + 1'b1;
                end
                if (r_wr_ptr == PTR_W'(mahd_pkg::MAX_WINDOW - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + 1'b1;
                end
            end
            if (r1_valid) begin
                r_window_sum <= n_window_sum;
            end
            if (w_res_fire) begin
                r_in_sound <= !r_in_sound;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r1_sample     <= i_s_tdata;
            r1_full       <= r_sample_index >= IDX_W'(w_len);
            r1_prod_start <= n_prod_start;
            r1_prod_end   <= n_prod_end;
            r1_pos        <= POS_W'(r_sample_index) - POS_W'(w_len);
        end
        if (w_en && r1_valid) begin
            r2_prod_start <= r1_prod_start;
            r2_prod_end   <= r1_prod_end;
            r2_pos        <= r1_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_res_fire;
                r_out       <= w_res;
            end
        end else if (w_res_fire) begin
            r_skid_valid <= 1'b1;
            r_skid       <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = mahd_pkg::OUT_DATA_W'(r_out.position);

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_state_flips_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_in_sound != $past(r_in_sound)) == $past(w_res_fire)))
        else $error("detector state changed without an event, or an event left it unchanged");

    a_index_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_sample_index >= $past(r_sample_index)))
        else $error("sample index went backward");

    a_index_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_in_fire)) |-> $stable(r_sample_index))
        else $error("sample index moved without an accepted item");

endmodule
